// ----- sv/bmtm_pkg.sv -----
// bmtm_pkg: shared types, constants and state codes of the battery monitor filter
// depends on: nothing
`timescale 1ns / 1ps

package bmtm_pkg;

    localparam int WINDOW              = 10;
    localparam int BEEP_INTERVAL_TICKS = 10000;

    localparam int NCH       = 5;
    localparam int NGAIN     = 4;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 18;
    localparam int POS_W     = 6;
    localparam int GAIN_W    = 24;
    localparam int MV_W      = 20;
    localparam int THR_W     = 16;
    localparam int TICK_W    = 32;
    localparam int POWER_W   = 32;
    localparam int ARITH_W   = 48;
    localparam int CNT_W     = 6;
    localparam int DIVS_W    = 24;
    localparam int NUM_W     = 41;
    localparam int DIFF_W    = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [SAMPLE_W-1:0] VREF_MV        = 12'd3300;
    localparam logic [SAMPLE_W-1:0] ADC_FULL_SCALE = 12'd4095;
    localparam logic [DIFF_W-1:0]   CHARGE_OFFSET  = 22'd225;
    localparam logic [DIFF_W-1:0]   CHARGE_MIN_D   = 22'd10;
    localparam logic [MV_W-1:0]     CHARGER_MIN_MV = 20'd5000;
    localparam logic [3:0]          MAX_BEEPS      = 4'd10;
    localparam logic [SAMPLE_W-1:0] POWER_DIVISOR  = 12'd10;

    localparam logic [CNT_W-1:0] CNT_AVG   = CNT_W'(SUM_W);
    localparam logic [CNT_W-1:0] CNT_SMALL = CNT_W'(SAMPLE_W);
    localparam logic [CNT_W-1:0] CNT_SUP   = CNT_W'(24);
    localparam logic [CNT_W-1:0] CNT_CHDIV = CNT_W'(36);
    localparam logic [CNT_W-1:0] CNT_GAIN  = CNT_W'(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_PMUL  = CNT_W'(21);
    localparam logic [CNT_W-1:0] CNT_PDIV  = CNT_W'(NUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_VREF_CAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CHG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HEAT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SENSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_HYST   = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] battery_sample;
        logic [SAMPLE_W-1:0] charger_detect_sample;
        logic [SAMPLE_W-1:0] heater_sample;
        logic [SAMPLE_W-1:0] charger_current_sample;
        logic [SAMPLE_W-1:0] reference_sample;
        logic                charger_enabled;
        logic [TICK_W-1:0]   tick_now;
    } in_t;

    typedef struct packed {
        logic [MV_W-1:0]    battery_mv;
        logic [MV_W-1:0]    charger_mv;
        logic [MV_W-1:0]    heater_mv;
        logic [MV_W-1:0]    charger_sense_mv;
        logic [THR_W-1:0]   supply_mv;
        logic               battery_full;
        logic               battery_low;
        logic               beep;
        logic [POWER_W-1:0] charge_power_mw;
    } out_t;

    typedef struct packed {
        logic               start;
        logic               is_div;
        logic [CNT_W-1:0]   count;
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ARITH_W-1:0] result;
    } arith_resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_REF,
        ST_MUL_F,
        ST_MUL_DEN,
        ST_SUPPLY,
        ST_CH_MUL,
        ST_CH_DIV,
        ST_CH_GAIN,
        ST_FLAGS,
        ST_PWR_MUL,
        ST_PWR_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- sv/bmtm_arith.sv -----
// bmtm_arith: bit-serial shift-add multiplier and restoring divider, one bit per cycle
// depends on: bmtm_pkg
`timescale 1ns / 1ps

module bmtm_arith (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bmtm_pkg::arith_req_t   req,
    output bmtm_pkg::arith_resp_t  resp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic                             is_div_reg, is_div_next;
    logic [bmtm_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [bmtm_pkg::ARITH_W-1:0]     acc_reg, acc_next;
    logic [bmtm_pkg::ARITH_W-1:0]     opa_reg, opa_next;
    logic [bmtm_pkg::ARITH_W-1:0]     opb_reg, opb_next;
    logic [bmtm_pkg::DIVS_W-1:0]      rem_reg, rem_next;
    logic [bmtm_pkg::DIVS_W-1:0]      dvs_reg, dvs_next;

    logic [bmtm_pkg::ARITH_W-1:0]     mul_sum;
    logic [bmtm_pkg::DIVS_W:0]        trial;
    logic [bmtm_pkg::DIVS_W:0]        diff;
    logic                             ge;
    logic [bmtm_pkg::CNT_W-1:0]       align;

    assign mul_sum = acc_reg + (opb_reg[0] ? opa_reg : '0);
    assign trial   = {rem_reg, acc_reg[bmtm_pkg::ARITH_W-1]};
    assign ge      = trial >= {1'b0, dvs_reg};
    assign diff    = trial - {1'b0, dvs_reg};
    assign align   = bmtm_pkg::CNT_W'(bmtm_pkg::ARITH_W) - req.count;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            is_div_next = req.is_div;
            cnt_next    = req.count;
            rem_next    = '0;
            dvs_next    = req.b[bmtm_pkg::DIVS_W-1:0];
            opa_next    = req.a;
            opb_next    = req.b;
            acc_next    = req.is_div ? (req.a << align) : '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bmtm_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (is_div_reg) begin
                rem_next = ge ? diff[bmtm_pkg::DIVS_W-1:0] : trial[bmtm_pkg::DIVS_W-1:0];
                acc_next = {acc_reg[bmtm_pkg::ARITH_W-2:0], ge};
            end else begin
                acc_next = mul_sum;
                opa_next = {opa_reg[bmtm_pkg::ARITH_W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[bmtm_pkg::ARITH_W-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        is_div_reg <= is_div_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
    end

    assign resp.busy   = busy_reg;
    assign resp.done   = done_reg;
    assign resp.result = acc_reg;

endmodule

// ----- sv/battery_monitor_trimmed_mean.sv -----
// battery_monitor_trimmed_mean: block trimmed-mean filter, supply correction, alarm, power
// depends on: bmtm_pkg, bmtm_arith
//
//  channel   ports                          request moves
//  input     s_valid, s_ready, s_data       one set of five samples, flag and tick
//  result    m_valid, m_ready, m_data       one result per block of WINDOW sets
//  config    cfg_wr_en, cfg_index, cfg_data one register write, no wait
//
// a non-final set of a block is accumulated while idle, with no unit operation
// the final set starts a sequence on one bit-serial multiply/divide unit, one bit per
// cycle: five averaging divides, two multiplies and a divide for the supply, then a
// multiply, divide and gain multiply per channel for four channels, then the flags and,
// when the charge power applies, a power multiply and divide
// s_ready is low during that sequence; the result waits in an output register
// synchronous active-low reset, no clearing pass
`timescale 1ns / 1ps

module battery_monitor_trimmed_mean (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bmtm_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bmtm_pkg::out_t                      m_data,
    input  logic                                cfg_wr_en,
    input  logic [bmtm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmtm_pkg::CFG_W-1:0]          cfg_data
);

    bmtm_pkg::state_t state_reg, state_next;

    logic [bmtm_pkg::SAMPLE_W-1:0] vref_cal_reg;
    logic [bmtm_pkg::GAIN_W-1:0]   gain_reg [bmtm_pkg::NGAIN];
    logic [bmtm_pkg::THR_W-1:0]    full_thr_reg, low_thr_reg, low_hyst_reg;

    logic [bmtm_pkg::SUM_W-1:0]    sum_reg [bmtm_pkg::NCH];
    logic [bmtm_pkg::SAMPLE_W-1:0] min_reg [bmtm_pkg::NCH];
    logic [bmtm_pkg::SAMPLE_W-1:0] max_reg [bmtm_pkg::NCH];
    logic [bmtm_pkg::SAMPLE_W-1:0] avg_reg [bmtm_pkg::NCH];
    logic [bmtm_pkg::MV_W-1:0]     mv_reg  [bmtm_pkg::NGAIN];
    logic [bmtm_pkg::POS_W-1:0]    pos_reg;
    logic [bmtm_pkg::SAMPLE_W-1:0] ref_avg_reg;
    logic                          low_latched_reg;
    logic [3:0]                    beep_count_reg;
    logic                          alarm_active_reg;
    logic [bmtm_pkg::TICK_W-1:0]   last_beep_tick_reg;

    logic [2:0]                    ch_reg;
    logic                          go_reg;
    logic [bmtm_pkg::DIVS_W-1:0]   f_reg, den_reg, smv_reg;
    logic [bmtm_pkg::NUM_W-1:0]    num_reg;
    logic [bmtm_pkg::THR_W-1:0]    supply_reg;
    logic [bmtm_pkg::TICK_W-1:0]   tick_reg;
    logic                          chg_en_reg;
    logic                          beep_reg, full_reg;
    logic [bmtm_pkg::MV_W:0]       d_reg;
    logic [bmtm_pkg::POWER_W-1:0]  power_reg;
    logic                          m_valid_reg;
    bmtm_pkg::out_t                out_reg;

    bmtm_pkg::arith_req_t          areq;
    bmtm_pkg::arith_resp_t         aresp;

    logic [bmtm_pkg::SAMPLE_W-1:0] samp [bmtm_pkg::NCH];
    logic                          in_accept;
    logic                          last_set;
    logic [bmtm_pkg::SAMPLE_W:0]   cut;
    logic [bmtm_pkg::SUM_W-1:0]    trimmed;
    logic                          ref_ok;
    logic [bmtm_pkg::MV_W-1:0]     bat, chg, sense;
    logic [bmtm_pkg::THR_W:0]      low_clear;
    logic [bmtm_pkg::TICK_W-1:0]   tick_gap;
    logic [bmtm_pkg::DIFF_W-1:0]   dval;
    logic                          pwr_go;
    logic [31:0]                   scaled;

    bmtm_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .resp    (aresp)
    );

    assign samp[0] = s_data.battery_sample;
    assign samp[1] = s_data.charger_detect_sample;
    assign samp[2] = s_data.heater_sample;
    assign samp[3] = s_data.charger_current_sample;
    assign samp[4] = s_data.reference_sample;

    assign in_accept = s_valid && s_ready;
    assign last_set  = pos_reg == bmtm_pkg::POS_W'(bmtm_pkg::WINDOW - 1);
    assign ref_ok    = ref_avg_reg != '0;

    assign cut     = {1'b0, min_reg[ch_reg]} + {1'b0, max_reg[ch_reg]};
    assign trimmed = (sum_reg[ch_reg] >= bmtm_pkg::SUM_W'(cut))
                   ? sum_reg[ch_reg] - bmtm_pkg::SUM_W'(cut) : '0;

    assign bat       = mv_reg[0];
    assign chg       = mv_reg[1];
    assign sense     = mv_reg[3];
    assign low_clear = {1'b0, low_thr_reg} + {1'b0, low_hyst_reg};
    assign tick_gap  = tick_reg - last_beep_tick_reg;
    assign dval      = {2'b0, sense} - {2'b0, bat} - bmtm_pkg::CHARGE_OFFSET;
    assign pwr_go    = chg_en_reg && (chg > bmtm_pkg::CHARGER_MIN_MV)
                    && !dval[bmtm_pkg::DIFF_W-1] && (dval > bmtm_pkg::CHARGE_MIN_D);
    assign scaled    = aresp.result[47:16];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmtm_pkg::ST_IDLE:
                if (in_accept && last_set) state_next = bmtm_pkg::ST_AVG;
            bmtm_pkg::ST_AVG:
                if (aresp.done && ch_reg == 3'd4) state_next = bmtm_pkg::ST_REF;
            bmtm_pkg::ST_REF:
                state_next = bmtm_pkg::ST_MUL_F;
            bmtm_pkg::ST_MUL_F:
                if (aresp.done) state_next = bmtm_pkg::ST_MUL_DEN;
            bmtm_pkg::ST_MUL_DEN:
                if (aresp.done) state_next = bmtm_pkg::ST_SUPPLY;
            bmtm_pkg::ST_SUPPLY:
                if (aresp.done) state_next = bmtm_pkg::ST_CH_MUL;
            bmtm_pkg::ST_CH_MUL:
                if (aresp.done) state_next = bmtm_pkg::ST_CH_DIV;
            bmtm_pkg::ST_CH_DIV:
                if (aresp.done) state_next = bmtm_pkg::ST_CH_GAIN;
            bmtm_pkg::ST_CH_GAIN:
                if (aresp.done) begin
                    state_next = (ch_reg == 3'd3) ? bmtm_pkg::ST_FLAGS : bmtm_pkg::ST_CH_MUL;
                end
            bmtm_pkg::ST_FLAGS:
                state_next = pwr_go ? bmtm_pkg::ST_PWR_MUL : bmtm_pkg::ST_OUT;
            bmtm_pkg::ST_PWR_MUL:
                if (aresp.done) state_next = bmtm_pkg::ST_PWR_DIV;
            bmtm_pkg::ST_PWR_DIV:
                if (aresp.done) state_next = bmtm_pkg::ST_OUT;
            bmtm_pkg::ST_OUT:
                if (!m_valid_reg || m_ready) state_next = bmtm_pkg::ST_IDLE;
            default:
                state_next = bmtm_pkg::ST_IDLE;
        endcase
    end

    // unit requests and handshake
    always_comb begin
        s_ready     = state_reg == bmtm_pkg::ST_IDLE;
        areq.start  = 1'b0;
        areq.is_div = 1'b0;
        areq.count  = bmtm_pkg::CNT_SMALL;
        areq.a      = '0;
        areq.b      = '0;
        case (state_reg)
            bmtm_pkg::ST_AVG: begin
                areq.start  = go_reg;
                areq.is_div = 1'b1;
                areq.count  = bmtm_pkg::CNT_AVG;
                areq.a      = bmtm_pkg::ARITH_W'(trimmed);
                areq.b      = bmtm_pkg::ARITH_W'(bmtm_pkg::WINDOW - 2);
            end
            bmtm_pkg::ST_MUL_F: begin
                areq.start = go_reg;
                areq.a     = ref_ok ? bmtm_pkg::ARITH_W'(vref_cal_reg) : bmtm_pkg::ARITH_W'(1);
                areq.b     = bmtm_pkg::ARITH_W'(bmtm_pkg::VREF_MV);
            end
            bmtm_pkg::ST_MUL_DEN: begin
                areq.start = go_reg;
                areq.a     = bmtm_pkg::ARITH_W'(bmtm_pkg::ADC_FULL_SCALE);
                areq.b     = ref_ok ? bmtm_pkg::ARITH_W'(ref_avg_reg) : bmtm_pkg::ARITH_W'(1);
            end
            bmtm_pkg::ST_SUPPLY: begin
                areq.start  = go_reg;
                areq.is_div = 1'b1;
                areq.count  = bmtm_pkg::CNT_SUP;
                areq.a      = bmtm_pkg::ARITH_W'(f_reg);
                areq.b      = ref_ok ? bmtm_pkg::ARITH_W'(ref_avg_reg) : bmtm_pkg::ARITH_W'(1);
            end
            bmtm_pkg::ST_CH_MUL: begin
                areq.start = go_reg;
                areq.a     = bmtm_pkg::ARITH_W'(f_reg);
                areq.b     = bmtm_pkg::ARITH_W'(avg_reg[ch_reg]);
            end
            bmtm_pkg::ST_CH_DIV: begin
                areq.start  = go_reg;
                areq.is_div = 1'b1;
                areq.count  = bmtm_pkg::CNT_CHDIV;
                areq.a      = bmtm_pkg::ARITH_W'(num_reg);
                areq.b      = bmtm_pkg::ARITH_W'(den_reg);
            end
            bmtm_pkg::ST_CH_GAIN: begin
                areq.start = go_reg;
                areq.count = bmtm_pkg::CNT_GAIN;
                areq.a     = bmtm_pkg::ARITH_W'(smv_reg);
                areq.b     = bmtm_pkg::ARITH_W'(gain_reg[ch_reg[1:0]]);
            end
            bmtm_pkg::ST_PWR_MUL: begin
                areq.start = go_reg;
                areq.count = bmtm_pkg::CNT_PMUL;
                areq.a     = bmtm_pkg::ARITH_W'(chg);
                areq.b     = bmtm_pkg::ARITH_W'(d_reg);
            end
            bmtm_pkg::ST_PWR_DIV: begin
                areq.start  = go_reg;
                areq.is_div = 1'b1;
                areq.count  = bmtm_pkg::CNT_PDIV;
                areq.a      = bmtm_pkg::ARITH_W'(num_reg);
                areq.b      = bmtm_pkg::ARITH_W'(bmtm_pkg::POWER_DIVISOR);
            end
            default: begin
                areq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= bmtm_pkg::ST_IDLE;
            vref_cal_reg       <= 12'd1520;
            for (int i = 0; i < bmtm_pkg::NGAIN; i++) gain_reg[i] <= 24'd661295;
            full_thr_reg       <= 16'd25200;
            low_thr_reg        <= 16'd21000;
            low_hyst_reg       <= 16'd500;
            for (int i = 0; i < bmtm_pkg::NCH; i++) sum_reg[i] <= '0;
            pos_reg            <= '0;
            ref_avg_reg        <= '0;
            low_latched_reg    <= 1'b0;
            beep_count_reg     <= '0;
            alarm_active_reg   <= 1'b0;
            last_beep_tick_reg <= '0;
            ch_reg             <= '0;
            go_reg             <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    bmtm_pkg::CFG_VREF_CAL:   vref_cal_reg <= cfg_data[11:0];
                    bmtm_pkg::CFG_GAIN_BAT:   gain_reg[0]  <= cfg_data;
                    bmtm_pkg::CFG_GAIN_CHG:   gain_reg[1]  <= cfg_data;
                    bmtm_pkg::CFG_GAIN_HEAT:  gain_reg[2]  <= cfg_data;
                    bmtm_pkg::CFG_GAIN_SENSE: gain_reg[3]  <= cfg_data;
                    bmtm_pkg::CFG_FULL_THR:   full_thr_reg <= cfg_data[15:0];
                    bmtm_pkg::CFG_LOW_THR:    low_thr_reg  <= cfg_data[15:0];
                    bmtm_pkg::CFG_LOW_HYST:   low_hyst_reg <= cfg_data[15:0];
                    default:                  vref_cal_reg <= vref_cal_reg;
                endcase
            end

            if (areq.start) go_reg <= 1'b0;
            else if (aresp.done) go_reg <= 1'b1;

            if (state_reg == bmtm_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                bmtm_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        for (int i = 0; i < bmtm_pkg::NCH; i++) begin
                            if (pos_reg == '0) begin
                                sum_reg[i] <= bmtm_pkg::SUM_W'(samp[i]);
                            end else begin
                                sum_reg[i] <= sum_reg[i] + bmtm_pkg::SUM_W'(samp[i]);
                            end
                        end
                        pos_reg    <= last_set ? '0 : pos_reg + 1'b1;
                        ch_reg     <= '0;
                        go_reg     <= 1'b1;
                        tick_reg   <= s_data.tick_now;
                        chg_en_reg <= s_data.charger_enabled;
                    end
                end
                bmtm_pkg::ST_AVG: begin
                    if (aresp.done) begin
                        avg_reg[ch_reg] <= aresp.result[11:0];
                        ch_reg          <= (ch_reg == 3'd4) ? 3'd0 : ch_reg + 1'b1;
                    end
                end
                bmtm_pkg::ST_REF: begin
                    if (avg_reg[4] != '0) ref_avg_reg <= avg_reg[4];
                end
                bmtm_pkg::ST_MUL_F: begin
                    if (aresp.done) f_reg <= aresp.result[23:0];
                end
                bmtm_pkg::ST_MUL_DEN: begin
                    if (aresp.done) den_reg <= aresp.result[23:0];
                end
                bmtm_pkg::ST_SUPPLY: begin
                    if (aresp.done) begin
                        if (!ref_ok) supply_reg <= 16'd3300;
                        else if (aresp.result[47:16] != '0) supply_reg <= '1;
                        else supply_reg <= aresp.result[15:0];
                    end
                end
                bmtm_pkg::ST_CH_MUL: begin
                    if (aresp.done) num_reg <= aresp.result[bmtm_pkg::NUM_W-1:0];
                end
                bmtm_pkg::ST_CH_DIV: begin
                    if (aresp.done) smv_reg <= aresp.result[23:0];
                end
                bmtm_pkg::ST_CH_GAIN: begin
                    if (aresp.done) begin
                        mv_reg[ch_reg[1:0]] <= (scaled[31:20] != '0) ? '1 : scaled[19:0];
                        ch_reg              <= ch_reg + 1'b1;
                    end
                end
                bmtm_pkg::ST_FLAGS: begin
                    full_reg  <= bat >= bmtm_pkg::MV_W'(full_thr_reg);
                    beep_reg  <= 1'b0;
                    power_reg <= '0;
                    d_reg     <= dval[bmtm_pkg::MV_W:0];
                    if (bat <= bmtm_pkg::MV_W'(low_thr_reg)) begin
                        low_latched_reg <= 1'b1;
                        if (beep_count_reg < bmtm_pkg::MAX_BEEPS
                            && tick_gap >= bmtm_pkg::TICK_W'(bmtm_pkg::BEEP_INTERVAL_TICKS)) begin
                            beep_reg           <= 1'b1;
                            last_beep_tick_reg <= tick_reg;
                            beep_count_reg     <= beep_count_reg + 1'b1;
                            alarm_active_reg   <= 1'b1;
                        end
                    end else if (bat >= bmtm_pkg::MV_W'(low_clear)) begin
                        low_latched_reg <= 1'b0;
                        if (alarm_active_reg) begin
                            beep_count_reg   <= '0;
                            alarm_active_reg <= 1'b0;
                        end
                    end
                end
                bmtm_pkg::ST_PWR_MUL: begin
                    if (aresp.done) num_reg <= aresp.result[bmtm_pkg::NUM_W-1:0];
                end
                bmtm_pkg::ST_PWR_DIV: begin
                    if (aresp.done) begin
                        power_reg <= (aresp.result[47:32] != '0) ? '1 : aresp.result[31:0];
                    end
                end
                bmtm_pkg::ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.battery_mv       <= mv_reg[0];
                        out_reg.charger_mv       <= mv_reg[1];
                        out_reg.heater_mv        <= mv_reg[2];
                        out_reg.charger_sense_mv <= mv_reg[3];
                        out_reg.supply_mv        <= supply_reg;
                        out_reg.battery_full     <= full_reg;
                        out_reg.battery_low      <= low_latched_reg;
                        out_reg.beep             <= beep_reg;
                        out_reg.charge_power_mw  <= power_reg;
                    end
                end
                default: begin
                    go_reg <= go_reg;
                end
            endcase
        end
    end

    // min and max need no reset; the first set of each block overwrites them
    always_ff @(posedge aclk) begin
        if (state_reg == bmtm_pkg::ST_IDLE && in_accept) begin
            for (int i = 0; i < bmtm_pkg::NCH; i++) begin
                if (pos_reg == '0 || samp[i] < min_reg[i]) min_reg[i] <= samp[i];
                if (pos_reg == '0 || samp[i] > max_reg[i]) max_reg[i] <= samp[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_final_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && last_set) |=> (state_reg == bmtm_pkg::ST_AVG && go_reg))
        else $error("final set did not start the sequence");

    a_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bmtm_pkg::ST_IDLE) |-> !aresp.busy)
        else $error("arith unit busy while idle");

    a_beep_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        beep_count_reg <= bmtm_pkg::MAX_BEEPS)
        else $error("beep count above limit");
`endif

endmodule
